[hw/rtl/bdrp_pkg.sv]
`timescale 1ns / 1ps
package bdrp_pkg;

  // Block and offset geometry
  localparam int BLOCK_BYTES = 255;
  localparam int OFFSET_BITS = 32;
  localparam int COUNT_W     = 8;
  localparam int LANES       = 8;
  localparam int LANE_W      = $clog2(LANES);
  localparam int STORE_ROWS  = (BLOCK_BYTES + LANES - 1) / LANES;
  localparam int ROW_W       = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;
  localparam int WORD_W      = 8 * LANES;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  // One queue entry: a run to emit and/or an end-of-stream marker
  typedef struct packed {
    logic                   close;
    logic                   last;
    logic                   changes;
    logic [OFFSET_BITS-1:0] start;
    logic [COUNT_W-1:0]     count;
  } cmd_t;

  // Back end to front end: store read row and store release
  typedef struct packed {
    logic [ROW_W-1:0] rd_row;
    logic             release_store;
  } back_ctl_t;

endpackage

[hw/rtl/bdrp_queue.sv]
`timescale 1ns / 1ps
module bdrp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bdrp_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output bdrp_pkg::cmd_t head_cmd
);

  bdrp_pkg::cmd_t                     slots [bdrp_pkg::QUEUE_DEPTH];
  logic [bdrp_pkg::QPTR_W-1:0]        wr_ptr;
  logic [bdrp_pkg::QPTR_W-1:0]        rd_ptr;
  logic [bdrp_pkg::QCNT_W-1:0]        count;

  assign full     = (count == bdrp_pkg::QCNT_W'(bdrp_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign head_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue pop while empty");
`endif

endmodule

[hw/rtl/bdrp_front.sv]
`timescale 1ns / 1ps
module bdrp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           orig_byte,
  input  logic                 orig_present,
  input  logic [7:0]           new_byte,
  input  logic                 final_byte,
  input  logic                 q_full,
  output logic                 q_push,
  output bdrp_pkg::cmd_t       q_cmd,
  input  bdrp_pkg::back_ctl_t  back_ctl,
  output logic [bdrp_pkg::WORD_W-1:0] rd_data
);

  logic [bdrp_pkg::WORD_W-1:0]      mem [bdrp_pkg::STORE_ROWS];

  logic                             busy;
  logic                             in_run;
  logic [bdrp_pkg::OFFSET_BITS-1:0] run_start;
  logic [bdrp_pkg::COUNT_W-1:0]     run_count;
  logic [7:0]                       block_position;
  logic [bdrp_pkg::OFFSET_BITS-1:0] file_position;
  logic                             any_change;

  logic                             accept;
  logic [7:0]                       ref_byte;
  logic                             diff;
  logic                             close_eq;
  logic                             block_end;
  logic [7:0]                       bp_inc;
  logic [bdrp_pkg::COUNT_W-1:0]     wr_index;
  logic [bdrp_pkg::COUNT_W-1:0]     count_new;
  logic                             do_write;

  assign in_ready = !busy && !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    ref_byte  = orig_present ? orig_byte : 8'd0;
    diff      = (new_byte != ref_byte);
    close_eq  = in_run && !diff;
    bp_inc    = block_position + 8'd1;
    block_end = (bp_inc >= 8'(bdrp_pkg::BLOCK_BYTES)) || final_byte;
    wr_index  = in_run ? run_count : '0;
    do_write  = diff && (wr_index != {bdrp_pkg::COUNT_W{1'b1}});
    count_new = do_write ? wr_index + 1'b1 : wr_index;

    q_cmd.close   = close_eq || (block_end && diff);
    q_cmd.last    = final_byte;
    q_cmd.changes = any_change || diff;
    q_cmd.start   = (in_run) ? run_start : file_position;
    q_cmd.count   = close_eq ? run_count : count_new;
    q_push        = accept && (q_cmd.close || final_byte);
  end

  // Run store: one byte lane written per accepted differing byte
  always_ff @(posedge clk) begin
    if (accept && do_write) begin
      mem[wr_index[bdrp_pkg::LANE_W +: bdrp_pkg::ROW_W]]
        [{wr_index[bdrp_pkg::LANE_W-1:0], 3'b000} +: 8] <= new_byte;
    end
    rd_data <= mem[back_ctl.rd_row];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      in_run         <= 1'b0;
      run_start      <= '0;
      run_count      <= '0;
      block_position <= '0;
      file_position  <= '0;
      any_change     <= 1'b0;
    end else begin
      if (back_ctl.release_store) begin
        busy <= 1'b0;
      end else if (q_push && q_cmd.close) begin
        busy <= 1'b1;
      end
      if (accept) begin
        if (final_byte) begin
          in_run         <= 1'b0;
          run_start      <= '0;
          run_count      <= '0;
          block_position <= '0;
          file_position  <= '0;
          any_change     <= 1'b0;
        end else begin
          in_run         <= diff && !block_end;
          if (diff && !in_run) begin
            run_start <= file_position;
          end
          run_count      <= q_cmd.close ? '0 : (diff ? count_new : run_count);
          block_position <= block_end ? 8'd0 : bp_inc;
          file_position  <= file_position + 1'b1;
          any_change     <= any_change || diff;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_run_count_tracks: assert property (@(posedge clk) disable iff (rst)
    in_run == (run_count != '0))
    else $error("run count out of step with open run");
  a_block_pos_range: assert property (@(posedge clk) disable iff (rst)
    block_position < 8'(bdrp_pkg::BLOCK_BYTES))
    else $error("block position past block end");
`endif

endmodule

[hw/rtl/bdrp_back.sv]
`timescale 1ns / 1ps
module bdrp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  bdrp_pkg::cmd_t       q_head,
  output bdrp_pkg::back_ctl_t  back_ctl,
  input  logic [bdrp_pkg::WORD_W-1:0] rd_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           kind,
  output logic [31:0]          run_offset,
  output logic [7:0]           run_length,
  output logic [63:0]          data_word,
  output logic [3:0]           data_count,
  output logic                 run_end,
  output logic                 changes_found
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HEAD = 5'b00010,
    S_READ = 5'b00100,
    S_DATA = 5'b01000,
    S_END  = 5'b10000
  } state_t;

  state_t                       state;
  state_t                       state_next;
  bdrp_pkg::cmd_t               cmd;
  logic [bdrp_pkg::ROW_W-1:0]   row;
  logic [bdrp_pkg::COUNT_W-1:0] rem;

  logic                         slot_free;
  logic                         load;
  logic [3:0]                   word_n;
  logic                         word_last;
  logic [63:0]                  word_masked;

  assign slot_free              = !out_valid || out_ready;
  assign q_pop                  = (state == S_IDLE) && !q_empty;
  assign back_ctl.rd_row        = row;
  assign back_ctl.release_store = (state == S_DATA) && slot_free && word_last;

  always_comb begin
    word_n    = (rem > bdrp_pkg::COUNT_W'(8)) ? 4'd8 : rem[3:0];
    word_last = (rem <= bdrp_pkg::COUNT_W'(8));
    for (int i = 0; i < 8; i++) begin
      word_masked[8*i +: 8] = (4'(i) < word_n) ? rd_data[8*i +: 8] : 8'd0;
    end
  end

  always_comb begin
    state_next = state;
    load       = 1'b0;
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          state_next = q_head.close ? S_HEAD : S_END;
        end
      end
      S_HEAD: begin
        if (slot_free) begin
          load       = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_DATA;
      end
      S_DATA: begin
        if (slot_free) begin
          load = 1'b1;
          if (word_last) begin
            state_next = cmd.last ? S_END : S_IDLE;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_END: begin
        if (slot_free) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Payload registers: latch the command, walk rows, load results
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_head;
    end
    if (state == S_HEAD && slot_free) begin
      row <= '0;
      rem <= cmd.count;
    end else if (state == S_DATA && slot_free && !word_last) begin
      row <= row + 1'b1;
      rem <= rem - bdrp_pkg::COUNT_W'(8);
    end
    if (load) begin
      case (state)
        S_HEAD: begin
          kind          <= bdrp_pkg::KIND_HEADER;
          run_offset    <= 32'(cmd.start);
          run_length    <= 8'(cmd.count);
          data_word     <= '0;
          data_count    <= '0;
          run_end       <= 1'b0;
          changes_found <= 1'b0;
        end
        S_DATA: begin
          kind          <= bdrp_pkg::KIND_DATA;
          run_offset    <= '0;
          run_length    <= '0;
          data_word     <= word_masked;
          data_count    <= word_n;
          run_end       <= word_last;
          changes_found <= 1'b0;
        end
        default: begin
          kind          <= bdrp_pkg::KIND_END;
          run_offset    <= '0;
          run_length    <= '0;
          data_word     <= '0;
          data_count    <= '0;
          run_end       <= 1'b0;
          changes_found <= cmd.changes;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_data_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (state == S_DATA) |-> (rem != '0))
    else $error("data word with no bytes left");
  a_release_then_idle_or_end: assert property (@(posedge clk) disable iff (rst)
    back_ctl.release_store |=> (state == S_IDLE || state == S_END))
    else $error("store released mid-run");
`endif

endmodule

[hw/rtl/byte_diff_run_patch_encoder_core.sv]
`timescale 1ns / 1ps
// Byte-difference run patch encoder. Each input word pairs a byte of the
// original image (zero where orig_present is low) with the byte at the same
// offset of the modified image; maximal runs of differing bytes, cut at every
// 255-byte block boundary counted from offset zero, come out as a header word
// (kind 0: run_offset, run_length) followed by data words (kind 1: up to eight
// run bytes, first byte in bits 7..0, data_count valid bytes, run_end on the
// last). The word with final_byte set also yields an end word (kind 2) whose
// changes_found tells whether any byte differed; the encoder then restarts at
// offset zero. Rate: one input word per cycle while no run closes and the
// queue is not full. The run store is a single 32-row by 64-bit memory owned
// by the front end, so after an input word that closes a run, input stalls
// until the back end has sent the run out through the header slot and the
// read-then-emit loop over the store rows. A two-entry queue between front
// and back lets the output side stall without blocking bytes that close no
// run, as long as the queue has room.
module byte_diff_run_patch_encoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  orig_byte,
  input  logic        orig_present,
  input  logic [7:0]  new_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [31:0] run_offset,
  output logic [7:0]  run_length,
  output logic [63:0] data_word,
  output logic [3:0]  data_count,
  output logic        run_end,
  output logic        changes_found
);

  // Front end to queue
  logic                          q_push;
  logic                          q_full;
  bdrp_pkg::cmd_t                q_cmd;
  // Queue to back end
  logic                          q_pop;
  logic                          q_empty;
  bdrp_pkg::cmd_t                q_head;
  // Back end store access
  bdrp_pkg::back_ctl_t           back_ctl;
  logic [bdrp_pkg::WORD_W-1:0]   rd_data;

  // Classify bytes, track runs and blocks, fill the run store
  bdrp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .orig_byte    (orig_byte),
    .orig_present (orig_present),
    .new_byte     (new_byte),
    .final_byte   (final_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_cmd),
    .back_ctl     (back_ctl),
    .rd_data      (rd_data)
  );

  // Hold closed runs and end markers until the back end takes them
  bdrp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_cmd (q_head)
  );

  // Emit header, packed data words and end marker through the output register
  bdrp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_head        (q_head),
    .back_ctl      (back_ctl),
    .rd_data       (rd_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .run_offset    (run_offset),
    .run_length    (run_length),
    .data_word     (data_word),
    .data_count    (data_count),
    .run_end       (run_end),
    .changes_found (changes_found)
  );

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

  // One output word, laid out in port order so that it packs straight from the ports.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] offset;
    logic [7:0]  length;
    logic [63:0] bytes;
    logic [3:0]  n_bytes;
    logic        is_last;
    logic        changes;
  } patch_word_t;

  // Tracks the encoder state for every accepted byte pair and keeps the words it must emit.
  class patch_word_checker;
    patch_word_t expected_words[$];
    logic [7:0]  run_bytes[255];
    logic [31:0] run_start;
    int          run_len;
    bit          in_run;
    int          block_pos;
    logic [31:0] file_pos;
    bit          any_change;
    int          mismatches;

    function new();
      mismatches = 0;
      restart_image();
    endfunction

    function void restart_image();
      run_start  = '0;
      run_len    = 0;
      in_run     = 1'b0;
      block_pos  = 0;
      file_pos   = '0;
      any_change = 1'b0;
    endfunction

    function void expect_word(logic [1:0] k, logic [31:0] off, logic [7:0] len,
                              logic [63:0] bytes, logic [3:0] cnt, logic is_last,
                              logic chg);
      patch_word_t w;
      w = {k, off, len, bytes, cnt, is_last, chg};
      expected_words.push_back(w);
    endfunction

    // Header first, then the run bytes eight to a word, lowest byte first.
    function void queue_run();
      logic [63:0] packed_bytes;
      int          n;
      expect_word(bdrp_pkg::KIND_HEADER, run_start, 8'(run_len), '0, '0, 1'b0, 1'b0);
      for (int done = 0; done < run_len; done += 8) begin
        n = (run_len - done > 8) ? 8 : run_len - done;
        packed_bytes = '0;
        for (int i = 0; i < n; i++) packed_bytes[8*i +: 8] = run_bytes[done + i];
        expect_word(bdrp_pkg::KIND_DATA, '0, '0, packed_bytes, 4'(n),
                    (done + n >= run_len), 1'b0);
      end
      in_run  = 1'b0;
      run_len = 0;
    endfunction

    function void note_pair(logic [7:0] orig, logic present, logic [7:0] nb, logic fin);
      logic [7:0] base;
      bit         differs;
      base    = present ? orig : 8'h00;
      differs = (nb != base);
      // an equal byte closes the open run before it is counted
      if (in_run && !differs) queue_run();
      if (differs) begin
        if (!in_run) begin
          in_run    = 1'b1;
          run_start = file_pos;
          run_len   = 0;
        end
        if (run_len < 255) begin
          run_bytes[run_len] = nb;
          run_len++;
        end
        any_change = 1'b1;
      end
      // runs are cut at every block boundary and at the last byte
      block_pos = (block_pos + 1) & 8'hff;
      if (block_pos >= bdrp_pkg::BLOCK_BYTES || fin) begin
        if (in_run) queue_run();
        block_pos = 0;
      end
      file_pos = file_pos + 32'd1;
      if (fin) begin
        expect_word(bdrp_pkg::KIND_END, '0, '0, '0, '0, 1'b0, any_change);
        restart_image();
      end
    endfunction

    function void flag(string what, patch_word_t want, patch_word_t got);
      if (mismatches < 10) begin
        $display("%0t %s", $realtime, what);
        $display("  expected kind %0d off %h len %0d data %h cnt %0d end %b chg %b",
                 want.kind, want.offset, want.length, want.bytes, want.n_bytes,
                 want.is_last, want.changes);
        $display("  actual   kind %0d off %h len %0d data %h cnt %0d end %b chg %b",
                 got.kind, got.offset, got.length, got.bytes, got.n_bytes,
                 got.is_last, got.changes);
      end
      mismatches++;
    endfunction

    function void check_word(patch_word_t got);
      patch_word_t want;
      if (expected_words.size() == 0) begin
        flag("word with nothing expected", '0, got);
        return;
      end
      want = expected_words.pop_front();
      if (got !== want) flag("word mismatch", want, got);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  orig_byte = '0;
  logic        orig_present = 1'b0;
  logic [7:0]  new_byte = '0;
  logic        final_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [31:0] run_offset;
  logic [7:0]  run_length;
  logic [63:0] data_word;
  logic [3:0]  data_count;
  logic        run_end;
  logic        changes_found;

  patch_word_checker sb = new();
  int pairs_sent = 0;
  bit tx_busy = 1'b0;

  byte_diff_run_patch_encoder_core u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .orig_byte     (orig_byte),
    .orig_present  (orig_present),
    .new_byte      (new_byte),
    .final_byte    (final_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .run_offset    (run_offset),
    .run_length    (run_length),
    .data_word     (data_word),
    .data_count    (data_count),
    .run_end       (run_end),
    .changes_found (changes_found)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one byte pair after a random gap and hold it until the encoder takes it.
  task automatic send_pair(input logic present, input logic [7:0] orig,
                           input logic [7:0] nb, input logic fin);
    int gap;
    if (pairs_sent % 16 == 0) tx_busy = 1'($urandom_range(0, 1));
    gap = tx_busy ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    orig_present <= present;
    orig_byte    <= orig;
    new_byte     <= nb;
    final_byte   <= fin;
    do @(posedge clk); while (!in_ready);
    sb.note_pair(orig, present, nb, fin);
    pairs_sent++;
  endtask

  // A negative percentage sends raw random bytes; otherwise equal or differing by choice.
  task automatic send_random_pair(input int diff_pct, input logic fin);
    logic [7:0] orig;
    logic [7:0] nb;
    logic       present;
    orig    = 8'($urandom_range(0, 255));
    present = 1'($urandom_range(0, 1));
    if (diff_pct < 0)
      nb = 8'($urandom_range(0, 255));
    else if ($urandom_range(0, 99) < diff_pct)
      nb = (present ? orig : 8'h00) ^ 8'($urandom_range(1, 255));
    else
      nb = present ? orig : 8'h00;
    send_pair(present, orig, nb, fin);
  endtask

  initial begin : stimulus
    int len;
    int pct;
    bit long_done;
    long_done = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Runs of two and nine bytes closed by equal bytes, missing original bytes on both sides.
    send_pair(1'b1, 8'h00, 8'h00, 1'b0);
    send_pair(1'b1, 8'hff, 8'h00, 1'b0);
    send_pair(1'b0, 8'h3c, 8'hff, 1'b0);
    send_pair(1'b0, 8'hff, 8'h00, 1'b0);
    for (int i = 0; i < 9; i++) send_pair(1'b1, 8'h00, 8'(8'h11 * (i + 1)), 1'b0);
    send_pair(1'b1, 8'h80, 8'h80, 1'b0);
    send_pair(1'b1, 8'h7f, 8'h7f, 1'b1);
    // one-byte images: unchanged, then changed with the run closed by the last byte
    send_pair(1'b1, 8'h55, 8'h55, 1'b1);
    send_pair(1'b1, 8'h00, 8'hff, 1'b1);
    // run still open at the last byte
    send_pair(1'b0, 8'h00, 8'h01, 1'b0);
    send_pair(1'b1, 8'hff, 8'hfe, 1'b0);
    send_pair(1'b1, 8'h01, 8'h80, 1'b1);
    // no change at all, missing original equal to a zero new byte
    send_pair(1'b1, 8'ha5, 8'ha5, 1'b0);
    send_pair(1'b0, 8'hff, 8'h00, 1'b0);
    send_pair(1'b1, 8'h5a, 8'h5a, 1'b1);
    // equal last byte closes the run and ends the image in the same word
    send_pair(1'b1, 8'h10, 8'h20, 1'b0);
    send_pair(1'b1, 8'h33, 8'h33, 1'b1);

    // Hold the input until every expected word has come out.
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    while (pairs_sent < 290) begin
      if (!long_done && pairs_sent >= 25) begin
        // full-block run, cut at the boundary, continued in the next block
        len = 256 + $urandom_range(3, 12);
        for (int i = 0; i < len; i++) begin
          if (i < 259)
            send_random_pair(100, 1'b0);
          else
            send_random_pair(50, i == len - 1);
        end
        long_done = 1'b1;
      end else begin
        case ($urandom_range(0, 7))
          0:       pct = -1;
          1, 2:    pct = 15;
          3, 4:    pct = 50;
          default: pct = 85;
        endcase
        len = $urandom_range(1, 20);
        for (int i = 0; i < len; i++) send_random_pair(pct, i == len - 1);
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Take output words after random stalls; once, stall for a long stretch so input backs up.
  initial begin : result_sink
    int  wait_cycles;
    int  taken;
    bit  rx_busy;
    bit  held;
    taken   = 0;
    rx_busy = 1'b0;
    held    = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (taken % 16 == 0) rx_busy = 1'($urandom_range(0, 1));
      wait_cycles = rx_busy ? $urandom_range(0, 13) : 0;
      if (!held && taken == 30) begin
        wait_cycles = 400;
        held        = 1'b1;
      end
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_word({kind, run_offset, run_length, data_word, data_count, run_end,
                     changes_found});
      taken++;
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
